FILE: hw/rtl/blkpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blkpl_pkg
// Shared types, constants and the rank compare for the best-K placement list.
// ----------------------------------------------------------------------------
package blkpl_pkg;

    localparam int SCORE_BITS     = 16;
    localparam int LEVEL_BITS     = 6;
    localparam int REF_BITS       = 16;
    localparam int WORST_BITS     = SCORE_BITS + 1;
    localparam int COUNT_BITS     = 5;
    localparam int LIST_LEN_BITS  = 5;
    localparam int LIST_LEN_RESET = 10;
    localparam int QUEUE_DEPTH    = 2;

    // Worst score reported while the list is not yet full
    localparam logic [WORST_BITS-1:0] WORST_NOT_FULL = {1'b1, {SCORE_BITS{1'b0}}};

    // Input operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic {
        CMD_INSERT,
        CMD_READ
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } back_state_t;

    typedef struct packed {
        logic                  op;
        logic [SCORE_BITS-1:0] score;
        logic                  is_branch;
        logic                  has_taxonomy;
        logic [LEVEL_BITS-1:0] tax_levels;
        logic [REF_BITS-1:0]   node_ref;
        logic [REF_BITS-1:0]   taxonomy_ref;
    } cand_t;

    typedef struct packed {
        logic [WORST_BITS-1:0] worst_score;
        logic [COUNT_BITS-1:0] entry_count;
        logic                  entry_valid;
        logic [SCORE_BITS-1:0] entry_score;
        logic                  entry_branch;
        logic                  entry_has_tax;
        logic [LEVEL_BITS-1:0] entry_levels;
        logic [REF_BITS-1:0]   entry_node;
        logic [REF_BITS-1:0]   entry_tax;
        logic                  last;
    } result_t;

    typedef struct packed {
        logic [SCORE_BITS-1:0] score;
        logic                  branch;
        logic                  has_tax;
        logic [LEVEL_BITS-1:0] levels;
        logic [REF_BITS-1:0]   node;
        logic [REF_BITS-1:0]   tax;
    } entry_t;

    // Classified work item passed from front to back
    typedef struct packed {
        cmd_t   cmd;
        entry_t entry;
    } work_t;

    // True when a ranks strictly ahead of b
    function automatic logic ranks_before(entry_t a, entry_t b);
        logic res;
        if (a.score != b.score)
            res = (a.score < b.score);
        else if (a.branch != b.branch)
            res = !a.branch;
        else if (a.has_tax != b.has_tax)
            res = a.has_tax;
        else
            res = (a.levels > b.levels);
        return res;
    endfunction

endpackage

FILE: hw/rtl/blkpl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blkpl_front
// Accepts candidate transactions, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module blkpl_front
    import blkpl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cand_valid,
    output logic  cand_stall,
    input  cand_t cand,
    output logic  push,
    output work_t push_item,
    input  logic  q_full
);

    logic  vld_reg;
    logic  vld_next;
    work_t item_reg;
    work_t item_next;
    logic  accept;

    // Stall only while the held item cannot move on
    assign cand_stall = vld_reg && q_full;
    assign accept     = cand_valid && !cand_stall;
    assign push       = vld_reg && !q_full;
    assign push_item  = item_reg;

    // Classify the incoming transaction
    always_comb
    begin
        item_next           = item_reg;
        if (accept)
        begin
            item_next.cmd          = (cand.op == OP_READ) ? CMD_READ : CMD_INSERT;
            item_next.entry.score  = cand.score;
            item_next.entry.branch = cand.is_branch;
            item_next.entry.has_tax = cand.has_taxonomy;
            item_next.entry.levels = cand.tax_levels;
            item_next.entry.node   = cand.node_ref;
            item_next.entry.tax    = cand.taxonomy_ref;
        end
        vld_next = accept ? 1'b1 : (push ? 1'b0 : vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

FILE: hw/rtl/blkpl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blkpl_queue
// Short FIFO that decouples the classifying front from the list back end.
// ----------------------------------------------------------------------------
module blkpl_queue
    import blkpl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_item,
    input  logic  pop,
    output work_t head,
    output logic  full,
    output logic  empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    work_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    assign full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    // Never write into a full queue unless it pops in the same cycle, or read from an empty one
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

endmodule

FILE: hw/rtl/blkpl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blkpl_back
// Ranked cell array with parallel compare-and-shift insert, readout sequencer
// and registered result stage.
// ----------------------------------------------------------------------------
module blkpl_back
    import blkpl_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [LIST_LEN_BITS-1:0] cfg_data,
    input  work_t                    head,
    input  logic                     empty,
    output logic                     pop,
    output logic                     result_valid,
    input  logic                     result_stall,
    output result_t                  result
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > LIST_LEN_BITS) ? CNT_W : LIST_LEN_BITS;

    entry_t                   cell_reg  [MAX_ENTRIES];
    entry_t                   cell_next [MAX_ENTRIES];
    logic [CNT_W-1:0]         held_reg;
    logic [CNT_W-1:0]         held_next;
    logic [LIST_LEN_BITS-1:0] list_len_reg;
    logic [LIST_LEN_BITS-1:0] list_len_next;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic [IDX_W-1:0]         rd_idx_next;
    back_state_t              state_reg;
    back_state_t              state_next;
    logic                     rslt_vld_reg;
    logic                     rslt_vld_next;
    result_t                  rslt_reg;
    result_t                  rslt_next;

    logic [CNT_W-1:0]         len;
    logic [CNT_W-1:0]         cfg_len;
    logic [CNT_W-1:0]         len_m1;
    logic [MAX_ENTRIES-1:0]   stays;
    logic                     insert_ok;
    logic                     do_insert;
    logic                     cfg_we;
    logic                     slot_free;
    logic                     emit;
    result_t                  emit_data;
    logic [CNT_W-1:0]         ins_last;
    logic [CNT_W-1:0]         held_last;
    logic                     rd_last;
    entry_t                   rd_entry;

    // Clamp a written length to 1..MAX_ENTRIES
    function automatic logic [CNT_W-1:0] eff_len(logic [LIST_LEN_BITS-1:0] v);
        logic [CMP_W-1:0] w;
        logic [CNT_W-1:0] r;
        w = CMP_W'(v);
        if (w == '0)
            r = CNT_W'(1);
        else if (w > CMP_W'(MAX_ENTRIES))
            r = CNT_W'(MAX_ENTRIES);
        else
            r = CNT_W'(w);
        return r;
    endfunction

    assign len       = eff_len(list_len_reg);
    assign cfg_len   = eff_len(cfg_data);
    assign len_m1    = len - 1'b1;
    assign cfg_ready = (state_reg == BK_IDLE);
    assign cfg_we    = cfg_valid && cfg_ready;
    assign slot_free = !rslt_vld_reg || !result_stall;
    assign pop       = (state_reg == BK_IDLE) && !empty && slot_free;
    assign do_insert = pop && (head.cmd == CMD_INSERT);

    // Compare the candidate against every held cell at once
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
            stays[i] = (CNT_W'(i) < held_reg) && !ranks_before(head.entry, cell_reg[i]);
    end

    assign insert_ok = !stays[len_m1[IDX_W-1:0]];

    // Shift the cells behind the insert point down by one
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (!do_insert || !insert_ok || stays[i])
                cell_next[i] = cell_reg[i];
            else if (i == 0)
                cell_next[i] = head.entry;
            else if (stays[i-1])
                cell_next[i] = head.entry;
            else
                cell_next[i] = cell_reg[i-1];
        end
    end

    // Update count and length; a shorter length drops the worst entries
    always_comb
    begin
        held_next     = held_reg;
        list_len_next = list_len_reg;
        if (cfg_we)
        begin
            list_len_next = cfg_data;
            if (held_reg > cfg_len)
                held_next = cfg_len;
        end
        else if (do_insert && insert_ok && (held_reg < len))
            held_next = held_reg + 1'b1;
    end

    assign ins_last  = held_next - 1'b1;
    assign held_last = held_reg - 1'b1;
    assign rd_entry  = cell_reg[rd_idx_reg];
    assign rd_last   = ((CNT_W'(rd_idx_reg) + 1'b1) == held_reg) || (held_reg == '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (pop && (head.cmd == CMD_READ))
                    state_next = BK_READ;
            end
            BK_READ:
            begin
                if (slot_free && rd_last)
                    state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Result generation and readout index
    always_comb
    begin
        emit        = 1'b0;
        emit_data   = '0;
        rd_idx_next = rd_idx_reg;
        case (state_reg)
            BK_IDLE:
            begin
                rd_idx_next = '0;
                if (do_insert)
                begin
                    emit                  = 1'b1;
                    emit_data.entry_count = COUNT_BITS'(held_next);
                    emit_data.worst_score = (held_next < len) ? WORST_NOT_FULL
                        : WORST_BITS'(cell_next[ins_last[IDX_W-1:0]].score);
                    emit_data.last        = 1'b1;
                end
            end
            BK_READ:
            begin
                if (slot_free)
                begin
                    emit                  = 1'b1;
                    emit_data.entry_count = COUNT_BITS'(held_reg);
                    emit_data.worst_score = (held_reg < len) ? WORST_NOT_FULL
                        : WORST_BITS'(cell_reg[held_last[IDX_W-1:0]].score);
                    emit_data.last        = rd_last;
                    if (held_reg != '0)
                    begin
                        emit_data.entry_valid   = 1'b1;
                        emit_data.entry_score   = rd_entry.score;
                        emit_data.entry_branch  = rd_entry.branch;
                        emit_data.entry_has_tax = rd_entry.has_tax;
                        emit_data.entry_levels  = rd_entry.levels;
                        emit_data.entry_node    = rd_entry.node;
                        emit_data.entry_tax     = rd_entry.tax;
                    end
                    if (!rd_last)
                        rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            default:
            begin
                rd_idx_next = '0;
            end
        endcase
    end

    // Hold the result while the receiver stalls
    always_comb
    begin
        rslt_vld_next = emit ? 1'b1 : (result_stall ? rslt_vld_reg : 1'b0);
        rslt_next     = emit ? emit_data : rslt_reg;
    end

    assign result_valid = rslt_vld_reg;
    assign result       = rslt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            held_reg     <= '0;
            list_len_reg <= LIST_LEN_BITS'(LIST_LEN_RESET);
            rd_idx_reg   <= '0;
            rslt_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            list_len_reg <= list_len_next;
            rd_idx_reg   <= rd_idx_next;
            rslt_vld_reg <= rslt_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rslt_reg <= rslt_next;
        for (int i = 0; i < MAX_ENTRIES; i++)
            cell_reg[i] <= cell_next[i];
    end

    // Count never runs past the active length
    a_held_in_len: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= len)
        else $error("held count exceeds list length");

    // Readout index stays inside the held entries
    a_rd_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ) |-> ((CNT_W'(rd_idx_reg) < held_reg) || (held_reg == '0)))
        else $error("readout index past held entries");

    // An insert grows the list by at most one entry
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (do_insert && !cfg_we) |=>
            ((held_reg == $past(held_reg)) || (held_reg == $past(held_reg) + 1'b1)))
        else $error("insert changed count by more than one");

    // A result carrying an entry always comes from a non-empty list
    a_entry_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rslt_vld_reg && rslt_reg.entry_valid) |-> (rslt_reg.entry_count != '0))
        else $error("entry read out of an empty list");

endmodule

FILE: hw/rtl/best_k_placement_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_k_placement_list
// Keeps the best K candidate placements in rank order and reads them out.
// ----------------------------------------------------------------------------
// Usage:
//   cand channel (cand_valid / cand_stall / cand): op 0 inserts a candidate,
//   op 1 reads out the whole list. A transaction is taken on a rising edge
//   with cand_valid high and cand_stall low.
//   result channel (result_valid / result_stall / result): one result per
//   insert, one per held entry on readout (one empty result for an empty
//   list); last marks the final result of a transaction.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes list_len; it is
//   taken only while no readout runs, and lowering it drops the worst entries.
// Pipeline and throughput:
//   A transaction passes the front register and the queue; its result is
//   registered in the output stage, a readout's after it enters BK_READ.
//   The cell array compares and shifts combinationally, so inserts sustain
//   one per cycle unless stalled. A readout holds the back end and emits
//   one entry per cycle unless stalled, via the sequencer's one read port.
// Reset: list empty, list_len 10. A stalled result holds in the output
// register while the two-entry queue and front register absorb new input.
// ----------------------------------------------------------------------------
module best_k_placement_list
    import blkpl_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cand_valid,
    output logic                     cand_stall,
    input  cand_t                    cand,
    output logic                     result_valid,
    input  logic                     result_stall,
    output result_t                  result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [LIST_LEN_BITS-1:0] cfg_data
);

    logic  push;
    work_t push_item;
    logic  pop;
    work_t head;
    logic  q_full;
    logic  q_empty;

    // Accept and classify
    blkpl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (cand_valid),
        .cand_stall (cand_stall),
        .cand       (cand),
        .push       (push),
        .push_item  (push_item),
        .q_full     (q_full)
    );

    // Decouple front and back
    blkpl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Ranked list and result stage
    blkpl_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .head         (head),
        .empty        (q_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the best-K placement list.
// Drives candidate inserts and list readouts with random bursts and gaps, while
// the result side stalls on a pattern of its own. It also rewrites the list
// length between phases, once every pending result is back. A behavioral list
// predicts every result, and each accepted result is checked field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
    import blkpl_pkg::*;
();

    localparam int LIST_SLOTS  = 16;
    localparam int SETTLE_CYC  = 24;
    localparam int MAX_PRINTED = 100;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_EVERY_FOURTH,
        STALL_RUNS
    } stall_mode_t;

    logic                     clk;
    logic                     rst_n        = 1'b0;
    logic                     cand_valid   = 1'b0;
    logic                     cand_stall;
    cand_t                    cand         = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    result_t                  result;
    logic                     cfg_valid    = 1'b0;
    logic                     cfg_ready;
    logic [LIST_LEN_BITS-1:0] cfg_data     = '0;

    // Predicted list state
    entry_t                   list_slots [LIST_SLOTS];
    int                       held_entries = 0;
    logic [LIST_LEN_BITS-1:0] len_setting  = LIST_LEN_BITS'(LIST_LEN_RESET);

    result_t                  pending_results [$];
    int                       mismatches = 0;

    // Sender burst state
    int                       burst_left = 0;
    bit                       no_idle    = 1'b0;

    // Receiver stall state
    stall_mode_t              stall_mode  = STALL_NONE;
    logic [5:0]               stall_cycle = '0;

    best_k_placement_list #(
        .MAX_ENTRIES (LIST_SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cand_valid   (cand_valid),
        .cand_stall   (cand_stall),
        .cand         (cand),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // List predictor
    // ------------------------------------------------------------------

    // Effective list length: zero acts as one, large values clamp
    function automatic int kept_len();
        if (len_setting == 0)
            return 1;
        if (len_setting > LIST_SLOTS)
            return LIST_SLOTS;
        return int'(len_setting);
    endfunction

    // True when a ranks strictly ahead of b
    function automatic bit outranks(entry_t a, entry_t b);
        if (a.score != b.score)
            return a.score < b.score;
        if (a.branch != b.branch)
            return a.branch == 1'b0;
        if (a.has_tax != b.has_tax)
            return a.has_tax == 1'b1;
        return a.levels > b.levels;
    endfunction

    function automatic logic [WORST_BITS-1:0] worst_kept();
        if (held_entries < kept_len() || held_entries == 0)
            return WORST_NOT_FULL;
        return {1'b0, list_slots[held_entries-1].score};
    endfunction

    // Append one predicted result transaction
    task automatic add_prediction(input result_t r);
        pending_results.insert(pending_results.size(), r);
    endtask

    // Place one candidate behind every entry of no worse rank
    task automatic place_candidate(input cand_t c);
        entry_t  e;
        result_t r;
        int      len;
        int      pos;
        int      top;
        e.score   = c.score;
        e.branch  = c.is_branch;
        e.has_tax = c.has_taxonomy;
        e.levels  = c.tax_levels;
        e.node    = c.node_ref;
        e.tax     = c.taxonomy_ref;
        len = kept_len();
        pos = 0;
        while (pos < held_entries && !outranks(e, list_slots[pos]))
            pos++;
        if (pos < len)
        begin
            top = (held_entries < len) ? held_entries : len - 1;
            for (int i = top; i > pos; i--)
                list_slots[i] = list_slots[i-1];
            list_slots[pos] = e;
            if (held_entries < len)
                held_entries++;
        end
        r = '0;
        r.worst_score = worst_kept();
        r.entry_count = COUNT_BITS'(held_entries);
        r.last        = 1'b1;
        add_prediction(r);
    endtask

    // Emit the whole list, or one empty result when nothing is held
    task automatic read_out_list();
        result_t r;
        r = '0;
        r.worst_score = worst_kept();
        r.entry_count = COUNT_BITS'(held_entries);
        if (held_entries == 0)
        begin
            r.last = 1'b1;
            add_prediction(r);
        end
        for (int i = 0; i < held_entries; i++)
        begin
            r.entry_valid   = 1'b1;
            r.entry_score   = list_slots[i].score;
            r.entry_branch  = list_slots[i].branch;
            r.entry_has_tax = list_slots[i].has_tax;
            r.entry_levels  = list_slots[i].levels;
            r.entry_node    = list_slots[i].node;
            r.entry_tax     = list_slots[i].tax;
            r.last          = (i + 1 == held_entries);
            add_prediction(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("%0t ns: MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_result(input result_t got, input result_t want);
        if (got.worst_score !== want.worst_score)
            report_mismatch($sformatf("worst_score got %0d expected %0d",
                got.worst_score, want.worst_score));
        if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d expected %0d",
                got.entry_count, want.entry_count));
        if (got.entry_valid !== want.entry_valid)
            report_mismatch($sformatf("entry_valid got %0b expected %0b",
                got.entry_valid, want.entry_valid));
        if (got.entry_score !== want.entry_score)
            report_mismatch($sformatf("entry_score got %0d expected %0d",
                got.entry_score, want.entry_score));
        if (got.entry_branch !== want.entry_branch)
            report_mismatch($sformatf("entry_branch got %0b expected %0b",
                got.entry_branch, want.entry_branch));
        if (got.entry_has_tax !== want.entry_has_tax)
            report_mismatch($sformatf("entry_has_tax got %0b expected %0b",
                got.entry_has_tax, want.entry_has_tax));
        if (got.entry_levels !== want.entry_levels)
            report_mismatch($sformatf("entry_levels got %0d expected %0d",
                got.entry_levels, want.entry_levels));
        if (got.entry_node !== want.entry_node)
            report_mismatch($sformatf("entry_node got 0x%0h expected 0x%0h",
                got.entry_node, want.entry_node));
        if (got.entry_tax !== want.entry_tax)
            report_mismatch($sformatf("entry_tax got 0x%0h expected 0x%0h",
                got.entry_tax, want.entry_tax));
        if (got.last !== want.last)
            report_mismatch($sformatf("last got %0b expected %0b",
                got.last, want.last));
    endtask

    // Compare each accepted result transaction with the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result with none pending, entry_node 0x%0h",
                    result.entry_node));
            else
            begin
                want = pending_results.pop_front();
                check_result(result, want);
            end
        end
    end

    // Stall the result side on a pattern picked anew each time the 6-bit stall counter wraps
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1'b1;
        if (stall_cycle == '0)
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:         result_stall <= 1'b0;
            STALL_RANDOM:       result_stall <= 1'($urandom_range(0, 1));
            STALL_EVERY_FOURTH: result_stall <= (stall_cycle[1:0] == 2'b11);
            default:            result_stall <= (stall_cycle[3:2] == 2'b11);
        endcase
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic cand_t make_insert(input logic [SCORE_BITS-1:0] score,
                                          input logic                  branch,
                                          input logic                  has_tax,
                                          input logic [LEVEL_BITS-1:0] levels,
                                          input logic [REF_BITS-1:0]   node,
                                          input logic [REF_BITS-1:0]   tax);
        cand_t c;
        c.op           = OP_INSERT;
        c.score        = score;
        c.is_branch    = branch;
        c.has_taxonomy = has_tax;
        c.tax_levels   = levels;
        c.node_ref     = node;
        c.taxonomy_ref = tax;
        return c;
    endfunction

    // Readout with random don't-care fields
    function automatic cand_t make_readout();
        cand_t c;
        c = make_insert(SCORE_BITS'($urandom), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), LEVEL_BITS'($urandom_range(0, 63)),
                        REF_BITS'($urandom), REF_BITS'($urandom));
        c.op = OP_READ;
        return c;
    endfunction

    // Random candidate biased toward rank ties and score extremes
    function automatic cand_t random_candidate();
        logic [SCORE_BITS-1:0] score;
        logic [LEVEL_BITS-1:0] levels;
        case ($urandom_range(0, 3))
            0:       score = SCORE_BITS'($urandom_range(0, 7));
            1:       score = SCORE_BITS'($urandom);
            2:       score = ($urandom_range(0, 1) != 0) ? '0 : '1;
            default: score = SCORE_BITS'($urandom_range(65528, 65535));
        endcase
        if ($urandom_range(0, 1) != 0)
            levels = LEVEL_BITS'($urandom_range(0, 63));
        else
            levels = ($urandom_range(0, 2) == 0) ? 6'd63
                                                 : LEVEL_BITS'($urandom_range(0, 2));
        return make_insert(score, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           levels, REF_BITS'($urandom), REF_BITS'($urandom));
    endfunction

    // Send one transaction; open a new burst after a random gap when due
    task automatic send_cand(input cand_t c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = no_idle ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                cand_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cand       <= c;
        cand_valid <= 1'b1;
        do
            @(posedge clk);
        while (cand_stall);
        if (c.op == OP_INSERT)
            place_candidate(c);
        else
            read_out_list();
    endtask

    // Hold off the sender until every pending result is back, then settle
    task automatic wait_results_drained();
        cand_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Write list_len; the block must be idle
    task automatic write_list_len(input logic [LIST_LEN_BITS-1:0] len);
        cfg_data  <= len;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        len_setting = len;
        if (held_entries > kept_len())
            held_entries = kept_len();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_empty_readout();
        send_cand(make_readout());
    endtask

    // Walk every rank rule, equal-rank ties, field extremes and overflow
    task automatic test_rank_order();
        send_cand(make_insert(16'd100, 1'b0, 1'b1, 6'd5, 16'h0001, 16'h0010));
        send_cand(make_insert(16'd100, 1'b1, 1'b1, 6'd5, 16'h0002, 16'h0020));
        send_cand(make_insert(16'd100, 1'b0, 1'b0, 6'd0, 16'h0003, 16'h0030));
        send_cand(make_insert(16'd100, 1'b0, 1'b1, 6'd63, 16'h0004, 16'h0040));
        send_cand(make_insert(16'd100, 1'b0, 1'b1, 6'd5, 16'h0005, 16'h0050));
        send_cand(make_insert(16'd0, 1'b0, 1'b0, 6'd0, 16'h0000, 16'h0000));
        send_cand(make_insert(16'hFFFF, 1'b1, 1'b1, 6'd63, 16'hFFFF, 16'hFFFF));
        send_cand(make_insert(16'hFFFF, 1'b0, 1'b0, 6'd0, 16'hAAAA, 16'h5555));
        send_cand(make_insert(16'd99, 1'b1, 1'b0, 6'd0, 16'h0009, 16'h0090));
        send_cand(make_insert(16'd101, 1'b0, 1'b1, 6'd42, 16'h000A, 16'h00A0));
        send_cand(make_insert(16'hFFFF, 1'b1, 1'b1, 6'd63, 16'h000B, 16'h00B0));
        send_cand(make_insert(16'd50, 1'b0, 1'b1, 6'd21, 16'h000C, 16'h00C0));
        send_cand(make_insert(16'hFFFF, 1'b1, 1'b0, 6'd0, 16'h000D, 16'h00D0));
        send_cand(make_readout());
    endtask

    // Lower the length under a full list, then the zero and clamp settings
    task automatic test_list_length();
        wait_results_drained();
        write_list_len(5'd3);
        send_cand(make_readout());
        wait_results_drained();
        write_list_len(5'd0);
        send_cand(make_insert(16'd7, 1'b0, 1'b0, 6'd1, 16'h1234, 16'h4321));
        send_cand(make_insert(16'd0, 1'b1, 1'b1, 6'd2, 16'h5678, 16'h8765));
        send_cand(make_readout());
        wait_results_drained();
        write_list_len(5'd31);
    endtask

    // Phases of random traffic, each under its own list length
    task automatic test_random_traffic();
        int                       len_plan [8];
        logic [LIST_LEN_BITS-1:0] len;
        len_plan = '{16, 0, 31, 2, 1, 17, 10, 0};
        for (int phase = 0; phase < 8; phase++)
        begin
            no_idle = (phase == 2 || phase == 5);
            wait_results_drained();
            len = (phase == 7) ? LIST_LEN_BITS'($urandom_range(0, 31))
                               : LIST_LEN_BITS'(len_plan[phase]);
            write_list_len(len);
            for (int n = 0; n < 29; n++)
            begin
                // Pause mid-phase until the result side has caught up
                if (phase == 3 && n == 16)
                    wait_results_drained();
                if ($urandom_range(0, 7) == 0)
                    send_cand(make_readout());
                else
                    send_cand(random_candidate());
            end
            send_cand(make_readout());
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_readout();
        test_rank_order();
        test_list_length();
        test_random_traffic();
        wait_results_drained();
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                pending_results.size()));
        if (mismatches == 0)
            $display("best_k_placement_list: match");
        else
            $display("best_k_placement_list: mismatch");
        $finish;
    end

    // End a hung run
    initial
    begin
        #2000000;
        $display("best_k_placement_list: mismatch");
        $finish;
    end

endmodule

FILE: best_k_placement_list.f
hw/rtl/blkpl_pkg.sv
hw/rtl/blkpl_front.sv
hw/rtl/blkpl_queue.sv
hw/rtl/blkpl_back.sv
hw/rtl/best_k_placement_list.sv
tb/tb_top.sv
